// ===== rtl/core/ohash_pkg.sv =====
// ---------------------------------------------------------------------------
// ohash_pkg
// Shared types and constants for the open-addressed hash table: field
// widths, request, status and slot mark codes, and controller interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

package ohash_pkg;

   // field widths
   localparam int KEY_W      = 64;
   localparam int CODE_W     = 24;
   localparam int PAY_W      = 32;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 10;
   localparam int MOD_W      = 11;
   localparam int PRIME_W    = 10;
   localparam int MODE_W     = 2;
   localparam int TEN_W      = 16;
   localparam int SUM_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // remainder unit: key bits consumed per cycle
   localparam int DIV_DIGITS = 4;

   // register reset values
   localparam logic [MOD_W-1:0]   TABLE_SIZE_RESET   = 11'd1021;
   localparam logic [PRIME_W-1:0] SECOND_PRIME_RESET = 10'd1019;
   localparam logic [MODE_W-1:0]  PROBE_MODE_RESET   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_PRIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE   = 2'd2;

   // probe modes (codes 2 and 3 both act as the additive double hash)
   localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DH_SUB = 2'd1;

   // additive step offset and the collision mark for statistics
   localparam logic [MOD_W-1:0] STEP_OFFSET = 11'd11;
   localparam logic [MOD_W-1:0] TEN_PROBES  = 11'd10;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT,
      FUNC_SEARCH,
      FUNC_DELETE,
      FUNC_NOP
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED,
      STATUS_DUPLICATE,
      STATUS_FOUND,
      STATUS_NOT_FOUND,
      STATUS_DELETED,
      STATUS_FULL
   } status_type;

   typedef enum logic [1:0] {
      MARK_FREE,
      MARK_USED,
      MARK_GONE
   } mark_type;

   typedef enum logic [3:0] {
      CTRL_CLEAR,
      CTRL_IDLE,
      CTRL_DIV_KEY,
      CTRL_STEP_START,
      CTRL_STEP_WAIT,
      CTRL_CALC,
      CTRL_READ,
      CTRL_DECIDE,
      CTRL_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic key_done;
      logic step_start;
      logic init;
      logic calc;
      logic decide;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic req_nop;
      logic div_done;
      logic quad;
      logic probe_end;
      logic out_free;
   } dp_stat_type;

   // (a + b) mod m for a, b below m
   function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                                input logic [MOD_W-1:0] b,
                                                input logic [MOD_W-1:0] m);
      logic [MOD_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, m}) begin
         sum = sum - {1'b0, m};
      end
      return sum[MOD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ohash_rem.sv =====
// ---------------------------------------------------------------------------
// ohash_rem
// Two-lane restoring remainder unit: reduces a 64-bit dividend by two
// divisors at once, a few dividend bits per cycle, MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module ohash_rem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ohash_pkg::KEY_W-1:0] dividend,
   input  wire logic [ohash_pkg::MOD_W-1:0] divisor_a,
   input  wire logic [ohash_pkg::MOD_W-1:0] divisor_b,
   output logic      [ohash_pkg::MOD_W-1:0] rem_a,
   output logic      [ohash_pkg::MOD_W-1:0] rem_b,
   output logic                             done
);

   localparam int DIV_CYCLES = ohash_pkg::KEY_W / ohash_pkg::DIV_DIGITS;
   localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

   logic [ohash_pkg::KEY_W-1:0] shift_ff;
   logic [ohash_pkg::MOD_W-1:0] rem_a_ff, rem_b_ff, rem_a_in, rem_b_in;
   logic [ohash_pkg::MOD_W:0]   trial_a, trial_b;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        done_ff;

   // a few compare-subtract steps per cycle on both lanes
   always_comb begin
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      trial_a  = '0;
      trial_b  = '0;
      for (int i = 0; i < ohash_pkg::DIV_DIGITS; i++) begin
         trial_a = {rem_a_in, shift_ff[ohash_pkg::KEY_W-1-i]};
         if (trial_a >= {1'b0, divisor_a}) begin
            trial_a = trial_a - {1'b0, divisor_a};
         end
         rem_a_in = trial_a[ohash_pkg::MOD_W-1:0];
         trial_b = {rem_b_in, shift_ff[ohash_pkg::KEY_W-1-i]};
         if (trial_b >= {1'b0, divisor_b}) begin
            trial_b = trial_b - {1'b0, divisor_b};
         end
         rem_b_in = trial_b[ohash_pkg::MOD_W-1:0];
      end
   end

   // iteration counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(DIV_CYCLES);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - CNT_W'(1);
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   // dividend shifter and partial remainders
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= dividend;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
      end else if (cnt_ff != '0) begin
         shift_ff <= shift_ff << ohash_pkg::DIV_DIGITS;
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
      end
   end

   assign rem_a = rem_a_ff;
   assign rem_b = rem_b_ff;
   assign done  = done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ohash_ctrl.sv =====
// ---------------------------------------------------------------------------
// ohash_ctrl
// Sequencer for the hash table: clearing pass, key reduction, step reduction
// (double-hash modes), one probe per calc/read/decide round until decided.
// ---------------------------------------------------------------------------
`default_nettype none

module ohash_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire ohash_pkg::dp_stat_type  stat,
   output logic                         req_ready,
   output ohash_pkg::ctrl_cmd_type      cmd
);

   ohash_pkg::ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ohash_pkg::CTRL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ohash_pkg::CTRL_CLEAR: begin
            if (stat.clear_last) state_in = ohash_pkg::CTRL_IDLE;
         end
         ohash_pkg::CTRL_IDLE: begin
            if (req_valid && !stat.req_nop) state_in = ohash_pkg::CTRL_DIV_KEY;
         end
         ohash_pkg::CTRL_DIV_KEY: begin
            if (stat.div_done) begin
               state_in = stat.quad ? ohash_pkg::CTRL_CALC : ohash_pkg::CTRL_STEP_START;
            end
         end
         ohash_pkg::CTRL_STEP_START: begin
            state_in = ohash_pkg::CTRL_STEP_WAIT;
         end
         ohash_pkg::CTRL_STEP_WAIT: begin
            if (stat.div_done) state_in = ohash_pkg::CTRL_CALC;
         end
         ohash_pkg::CTRL_CALC: begin
            state_in = ohash_pkg::CTRL_READ;
         end
         ohash_pkg::CTRL_READ: begin
            state_in = ohash_pkg::CTRL_DECIDE;
         end
         ohash_pkg::CTRL_DECIDE: begin
            state_in = stat.probe_end ? ohash_pkg::CTRL_FINISH : ohash_pkg::CTRL_CALC;
         end
         ohash_pkg::CTRL_FINISH: begin
            if (stat.out_free) state_in = ohash_pkg::CTRL_IDLE;
         end
         default: begin
            state_in = ohash_pkg::CTRL_CLEAR;
         end
      endcase
   end

   // commands
   always_comb begin
      req_ready      = (state_ff == ohash_pkg::CTRL_IDLE);
      cmd.clear      = (state_ff == ohash_pkg::CTRL_CLEAR);
      cmd.load       = (state_ff == ohash_pkg::CTRL_IDLE) && req_valid && !stat.req_nop;
      cmd.key_done   = (state_ff == ohash_pkg::CTRL_DIV_KEY) && stat.div_done;
      cmd.step_start = (state_ff == ohash_pkg::CTRL_STEP_START);
      cmd.init       = ((state_ff == ohash_pkg::CTRL_DIV_KEY) && stat.div_done && stat.quad)
                       || ((state_ff == ohash_pkg::CTRL_STEP_WAIT) && stat.div_done);
      cmd.calc       = (state_ff == ohash_pkg::CTRL_CALC);
      cmd.decide     = (state_ff == ohash_pkg::CTRL_DECIDE);
      cmd.finish     = (state_ff == ohash_pkg::CTRL_FINISH) && stat.out_free;
   end

endmodule

`default_nettype wire

// ===== rtl/core/ohash_datapath.sv =====
// ---------------------------------------------------------------------------
// ohash_datapath
// Configuration registers, request capture, probe arithmetic, slot
// memories, statistics and the result register of the hash table.
// ---------------------------------------------------------------------------
`default_nettype none

module ohash_datapath #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int RECORD_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ohash_pkg::ctrl_cmd_type          cmd,
   output ohash_pkg::dp_stat_type                stat,
   input  wire logic [ohash_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [ohash_pkg::KEY_W-1:0]      req_entry_key,
   input  wire logic [ohash_pkg::CODE_W-1:0]     req_entry_code,
   input  wire logic [ohash_pkg::PAY_W-1:0]      req_entry_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [ohash_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [ohash_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic      [ohash_pkg::PAY_W-1:0]      rsp_payload_out,
   output logic      [ohash_pkg::MOD_W-1:0]      rsp_probe_count,
   output logic      [ohash_pkg::MOD_W-1:0]      rsp_element_count,
   output logic      [ohash_pkg::MOD_W-1:0]      rsp_max_collisions,
   output logic      [ohash_pkg::TEN_W-1:0]      rsp_reached_ten_count,
   output logic      [ohash_pkg::SUM_W-1:0]      rsp_total_collisions,
   input  wire logic                             csr_write_enable,
   input  wire logic [ohash_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ohash_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
   localparam int MW    = ohash_pkg::MOD_W;

   // configuration
   logic [MW-1:0]                    table_size_ff;
   logic [ohash_pkg::PRIME_W-1:0]    second_prime_ff;
   logic [ohash_pkg::MODE_W-1:0]     probe_mode_ff;

   // request and probe state
   logic [ohash_pkg::FUNC_W-1:0]     func_ff;
   logic [ohash_pkg::KEY_W-1:0]      key_ff;
   logic [ohash_pkg::CODE_W-1:0]     code_ff;
   logic [RECORD_WIDTH-1:0]          record_ff;
   logic [ohash_pkg::MODE_W-1:0]     mode_ff;
   logic [MW-1:0]                    m_ff, p_ff, m_in, p_in;
   logic [MW-1:0]                    base_ff, step_ff, acc_ff, inc_ff, two_ff, tries_ff;
   logic [IDX_W-1:0]                 pos_ff, clr_ff;

   // slot memories
   ohash_pkg::mark_type              mark_mem [TABLE_DEPTH];
   logic [ohash_pkg::KEY_W-1:0]      key_mem  [TABLE_DEPTH];
   logic [ohash_pkg::CODE_W-1:0]     code_mem [TABLE_DEPTH];
   logic [RECORD_WIDTH-1:0]          rec_mem  [TABLE_DEPTH];
   ohash_pkg::mark_type              rd_mark_ff;
   logic [ohash_pkg::KEY_W-1:0]      rd_key_ff;
   logic [ohash_pkg::CODE_W-1:0]     rd_code_ff;
   logic [RECORD_WIDTH-1:0]          rd_rec_ff;

   // statistics
   logic [OCC_W-1:0]                 occ_ff;
   logic [MW-1:0]                    max_ff;
   logic [ohash_pkg::TEN_W-1:0]      ten_ff;
   logic [ohash_pkg::SUM_W-1:0]      sum_ff;

   // decided result, waiting for the output register
   ohash_pkg::status_type            res_status_ff, dec_status;
   logic [IDX_W-1:0]                 res_slot_ff;
   logic [ohash_pkg::PAY_W-1:0]      res_pay_ff;
   logic [MW-1:0]                    res_tries_ff;

   // output register
   logic                             out_valid_ff;
   logic [ohash_pkg::STATUS_W-1:0]   out_status_ff;
   logic [ohash_pkg::SLOT_W-1:0]     out_slot_ff;
   logic [ohash_pkg::PAY_W-1:0]      out_pay_ff;
   logic [MW-1:0]                    out_tries_ff, out_elem_ff, out_max_ff;
   logic [ohash_pkg::TEN_W-1:0]      out_ten_ff;
   logic [ohash_pkg::SUM_W-1:0]      out_sum_ff;

   // remainder unit
   logic                             div_start;
   logic [ohash_pkg::KEY_W-1:0]      div_dividend;
   logic [MW-1:0]                    rem_a, rem_b;
   logic                             div_done;

   // probe decision
   logic                             hit, miss, collide, end_probe;
   logic                             write_slot, delete_slot, last_try;
   logic [MW-1:0]                    tries_inc;
   logic                             quad;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= ohash_pkg::TABLE_SIZE_RESET;
         second_prime_ff <= ohash_pkg::SECOND_PRIME_RESET;
         probe_mode_ff   <= ohash_pkg::PROBE_MODE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == ohash_pkg::CSR_TABLE_SIZE) begin
            table_size_ff <= csr_write_data[MW-1:0];
         end
         if (csr_index == ohash_pkg::CSR_SECOND_PRIME) begin
            second_prime_ff <= csr_write_data[ohash_pkg::PRIME_W-1:0];
         end
         if (csr_index == ohash_pkg::CSR_PROBE_MODE) begin
            probe_mode_ff <= csr_write_data[ohash_pkg::MODE_W-1:0];
         end
      end
   end

   // effective modulus and step prime
   always_comb begin
      if (table_size_ff == '0) begin
         m_in = MW'(1);
      end else if (32'(table_size_ff) > TABLE_DEPTH) begin
         m_in = MW'(TABLE_DEPTH);
      end else begin
         m_in = table_size_ff;
      end
      p_in = (second_prime_ff == '0) ? MW'(1) : MW'(second_prime_ff);
   end

   assign quad = (mode_ff == ohash_pkg::MODE_QUAD);

   // remainder unit: key by m and p, then step by m
   assign div_start    = cmd.load || cmd.step_start;
   assign div_dividend = cmd.load ? req_entry_key : ohash_pkg::KEY_W'(step_ff);

   ohash_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor_a (m_ff),
      .divisor_b (p_ff),
      .rem_a     (rem_a),
      .rem_b     (rem_b),
      .done      (div_done)
   );

   // probe decision for the slot just read
   always_comb begin
      hit = (rd_mark_ff == ohash_pkg::MARK_USED) && (rd_key_ff == key_ff)
            && (rd_code_ff == code_ff);
      tries_inc   = tries_ff + MW'(1);
      last_try    = (tries_inc == m_ff);
      miss        = 1'b0;
      collide     = 1'b0;
      write_slot  = 1'b0;
      delete_slot = 1'b0;
      end_probe   = 1'b1;
      dec_status  = ohash_pkg::STATUS_FULL;
      if (func_ff == ohash_pkg::FUNC_INSERT) begin
         if (hit) begin
            dec_status = ohash_pkg::STATUS_DUPLICATE;
         end else if (rd_mark_ff != ohash_pkg::MARK_USED) begin
            dec_status = ohash_pkg::STATUS_INSERTED;
            write_slot = 1'b1;
         end else begin
            miss      = 1'b1;
            collide   = 1'b1;
            end_probe = last_try;
         end
      end else if (rd_mark_ff == ohash_pkg::MARK_FREE) begin
         dec_status = ohash_pkg::STATUS_NOT_FOUND;
      end else if (hit) begin
         if (func_ff == ohash_pkg::FUNC_SEARCH) begin
            dec_status = ohash_pkg::STATUS_FOUND;
         end else begin
            dec_status  = ohash_pkg::STATUS_DELETED;
            delete_slot = 1'b1;
         end
      end else begin
         miss      = 1'b1;
         end_probe = last_try;
      end
   end

   // request capture and probe sequence
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         key_ff    <= req_entry_key;
         code_ff   <= req_entry_code;
         record_ff <= RECORD_WIDTH'(req_entry_payload);
         mode_ff   <= probe_mode_ff;
         m_ff      <= m_in;
         p_ff      <= p_in;
      end
      if (cmd.key_done) begin
         base_ff <= rem_a;
         step_ff <= (mode_ff == ohash_pkg::MODE_DH_SUB) ? (p_ff - rem_b)
                                                        : (ohash_pkg::STEP_OFFSET + rem_b);
      end
      if (cmd.init) begin
         acc_ff   <= '0;
         tries_ff <= '0;
         two_ff   <= (m_ff > MW'(2)) ? MW'(2) : MW'(0);
         if (quad) begin
            inc_ff <= (m_ff == MW'(1)) ? MW'(0) : MW'(1);
         end else begin
            inc_ff <= rem_a;
         end
      end
      if (cmd.calc) begin
         pos_ff <= IDX_W'(ohash_pkg::add_mod(base_ff, acc_ff, m_ff));
      end
      if (cmd.decide && !end_probe) begin
         tries_ff <= tries_inc;
         acc_ff   <= ohash_pkg::add_mod(acc_ff, inc_ff, m_ff);
         if (quad) begin
            inc_ff <= ohash_pkg::add_mod(inc_ff, two_ff, m_ff);
         end
      end
      if (cmd.decide && end_probe) begin
         res_status_ff <= dec_status;
         res_tries_ff  <= miss ? tries_inc : tries_ff;
         res_slot_ff   <= (dec_status == ohash_pkg::STATUS_FULL
                           || dec_status == ohash_pkg::STATUS_NOT_FOUND) ? '0 : pos_ff;
         res_pay_ff    <= (dec_status == ohash_pkg::STATUS_FOUND)
                          ? ohash_pkg::PAY_W'(rd_rec_ff) : '0;
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + IDX_W'(1);
      end
   end

   // slot marks: cleared after reset, written on insert and delete
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mark_mem[clr_ff] <= ohash_pkg::MARK_FREE;
      end else if (cmd.decide && write_slot) begin
         mark_mem[pos_ff] <= ohash_pkg::MARK_USED;
      end else if (cmd.decide && delete_slot) begin
         mark_mem[pos_ff] <= ohash_pkg::MARK_GONE;
      end
      rd_mark_ff <= mark_mem[pos_ff];
   end

   // slot contents
   always_ff @(posedge clock) begin
      if (cmd.decide && write_slot) begin
         key_mem[pos_ff]  <= key_ff;
         code_mem[pos_ff] <= code_ff;
         rec_mem[pos_ff]  <= record_ff;
      end
      rd_key_ff  <= key_mem[pos_ff];
      rd_code_ff <= code_mem[pos_ff];
      rd_rec_ff  <= rec_mem[pos_ff];
   end

   // occupancy and collision statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         max_ff <= '0;
         ten_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.decide) begin
         if (write_slot) begin
            occ_ff <= occ_ff + OCC_W'(1);
         end else if (delete_slot && occ_ff != '0) begin
            occ_ff <= occ_ff - OCC_W'(1);
         end
         if (collide) begin
            if (tries_inc > max_ff) max_ff <= tries_inc;
            if (tries_inc == ohash_pkg::TEN_PROBES && ten_ff != '1) begin
               ten_ff <= ten_ff + ohash_pkg::TEN_W'(1);
            end
            if (sum_ff != '1) sum_ff <= sum_ff + ohash_pkg::SUM_W'(1);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= ohash_pkg::SLOT_W'(res_slot_ff);
         out_pay_ff    <= res_pay_ff;
         out_tries_ff  <= res_tries_ff;
         out_elem_ff   <= MW'(occ_ff);
         out_max_ff    <= max_ff;
         out_ten_ff    <= ten_ff;
         out_sum_ff    <= sum_ff;
      end
   end

   // status to the controller
   always_comb begin
      stat.clear_last = (clr_ff == '1);
      stat.req_nop    = (req_func == ohash_pkg::FUNC_NOP);
      stat.div_done   = div_done;
      stat.quad       = quad;
      stat.probe_end  = end_probe;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_slot_index        = out_slot_ff;
   assign rsp_payload_out       = out_pay_ff;
   assign rsp_probe_count       = out_tries_ff;
   assign rsp_element_count     = out_elem_ff;
   assign rsp_max_collisions    = out_max_ff;
   assign rsp_reached_ten_count = out_ten_ff;
   assign rsp_total_collisions  = out_sum_ff;

endmodule

`default_nettype wire

// ===== rtl/core/open_addressing_hash_table.sv =====
// Sequence: the 4-bit-per-cycle remainder unit reduces the key, then in the
//   double-hash modes the step; each probe is then a calc/read/decide round
//   of the slot memory.
// Throughput: one item at a time; the next is taken once the result is in
//   the output register. A no-op request is taken while idle, with no result.
// Reset: synchronous; then a clearing pass marks every slot free, with no
//   item accepted (configuration writes are taken).
// ---------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressed hash table with insert, search and delete, quadratic or
// double-hash probing, and insert collision statistics.
// ---------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int RECORD_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ohash_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [ohash_pkg::KEY_W-1:0]      req_entry_key,
   input  wire logic [ohash_pkg::CODE_W-1:0]     req_entry_code,
   input  wire logic [ohash_pkg::PAY_W-1:0]      req_entry_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [ohash_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [ohash_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic      [ohash_pkg::PAY_W-1:0]      rsp_payload_out,
   output logic      [ohash_pkg::MOD_W-1:0]      rsp_probe_count,
   output logic      [ohash_pkg::MOD_W-1:0]      rsp_element_count,
   output logic      [ohash_pkg::MOD_W-1:0]      rsp_max_collisions,
   output logic      [ohash_pkg::TEN_W-1:0]      rsp_reached_ten_count,
   output logic      [ohash_pkg::SUM_W-1:0]      rsp_total_collisions,
   input  wire logic                             csr_write_enable,
   input  wire logic [ohash_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ohash_pkg::CSR_DATA_W-1:0] csr_write_data
);

   ohash_pkg::ctrl_cmd_type cmd;
   ohash_pkg::dp_stat_type  stat;

   // sequencer
   ohash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // storage and arithmetic
   ohash_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .RECORD_WIDTH (RECORD_WIDTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_func              (req_func),
      .req_entry_key         (req_entry_key),
      .req_entry_code        (req_entry_code),
      .req_entry_payload     (req_entry_payload),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_payload_out       (rsp_payload_out),
      .rsp_probe_count       (rsp_probe_count),
      .rsp_element_count     (rsp_element_count),
      .rsp_max_collisions    (rsp_max_collisions),
      .rsp_reached_ten_count (rsp_reached_ten_count),
      .rsp_total_collisions  (rsp_total_collisions),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ohash_checker.sv =====
// ---------------------------------------------------------------------------
// ohash_checker
// Port-level checks on the hash table, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module ohash_checker #(
   parameter int TABLE_DEPTH  = 1024
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [ohash_pkg::FUNC_W-1:0]     req_func,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [ohash_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [ohash_pkg::SLOT_W-1:0]     rsp_slot_index,
   input wire logic [ohash_pkg::PAY_W-1:0]      rsp_payload_out,
   input wire logic [ohash_pkg::MOD_W-1:0]      rsp_element_count
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_slot_index) && $stable(rsp_payload_out))
      else $error("stalled result changed");

   // a real request closes the input until it is done
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != ohash_pkg::FUNC_NOP |=> !req_ready)
      else $error("second item taken while one is at work");

   // only a found entry returns a record; misses report slot zero
   a_payload_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ohash_pkg::STATUS_FOUND |-> rsp_payload_out == '0)
      else $error("record returned without a hit");

   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ohash_pkg::STATUS_NOT_FOUND
                    || rsp_status == ohash_pkg::STATUS_FULL)
      |-> rsp_slot_index == '0 && 32'(rsp_element_count) <= TABLE_DEPTH)
      else $error("miss with slot index or count out of range");

endmodule

bind open_addressing_hash_table ohash_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the open-addressed hash table: directed and random
// insert/search/delete items under several table sizes, primes and probe
// modes, checked field by field against an in-bench table model.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 1024;

   typedef struct {
      ohash_pkg::func_type                func;
      logic [ohash_pkg::KEY_W-1:0]        key;
      logic [ohash_pkg::CODE_W-1:0]       code;
      logic [ohash_pkg::PAY_W-1:0]        pay;
   } request_type;

   typedef struct {
      ohash_pkg::status_type              status;
      logic [ohash_pkg::SLOT_W-1:0]       slot;
      logic [ohash_pkg::PAY_W-1:0]        pay;
      logic [ohash_pkg::MOD_W-1:0]        probes;
      logic [ohash_pkg::MOD_W-1:0]        elems;
      logic [ohash_pkg::MOD_W-1:0]        max_coll;
      logic [ohash_pkg::TEN_W-1:0]        ten;
      logic [ohash_pkg::SUM_W-1:0]        sum;
   } answer_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [ohash_pkg::FUNC_W-1:0]       req_func = '0;
   logic [ohash_pkg::KEY_W-1:0]        req_entry_key = '0;
   logic [ohash_pkg::CODE_W-1:0]       req_entry_code = '0;
   logic [ohash_pkg::PAY_W-1:0]        req_entry_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [ohash_pkg::STATUS_W-1:0]     rsp_status;
   logic [ohash_pkg::SLOT_W-1:0]       rsp_slot_index;
   logic [ohash_pkg::PAY_W-1:0]        rsp_payload_out;
   logic [ohash_pkg::MOD_W-1:0]        rsp_probe_count;
   logic [ohash_pkg::MOD_W-1:0]        rsp_element_count;
   logic [ohash_pkg::MOD_W-1:0]        rsp_max_collisions;
   logic [ohash_pkg::TEN_W-1:0]        rsp_reached_ten_count;
   logic [ohash_pkg::SUM_W-1:0]        rsp_total_collisions;
   logic                               csr_write_enable = 1'b0;
   logic [ohash_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [ohash_pkg::CSR_DATA_W-1:0]   csr_write_data = '0;

   open_addressing_hash_table u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_func              (req_func),
      .req_entry_key         (req_entry_key),
      .req_entry_code        (req_entry_code),
      .req_entry_payload     (req_entry_payload),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_payload_out       (rsp_payload_out),
      .rsp_probe_count       (rsp_probe_count),
      .rsp_element_count     (rsp_element_count),
      .rsp_max_collisions    (rsp_max_collisions),
      .rsp_reached_ten_count (rsp_reached_ten_count),
      .rsp_total_collisions  (rsp_total_collisions),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #4 clock = ~clock;

   // table model state
   logic [ohash_pkg::MOD_W-1:0]   cfg_size  = ohash_pkg::TABLE_SIZE_RESET;
   logic [ohash_pkg::PRIME_W-1:0] cfg_prime = ohash_pkg::SECOND_PRIME_RESET;
   logic [ohash_pkg::MODE_W-1:0]  cfg_mode  = ohash_pkg::PROBE_MODE_RESET;
   ohash_pkg::mark_type           slot_state [DEPTH];
   logic [ohash_pkg::KEY_W-1:0]   slot_keys  [DEPTH];
   logic [ohash_pkg::CODE_W-1:0]  slot_codes [DEPTH];
   logic [ohash_pkg::PAY_W-1:0]   slot_recs  [DEPTH];
   int unsigned                   used_slots = 0;
   int unsigned                   worst_probe = 0;
   int unsigned                   ten_hits = 0;
   longint unsigned               coll_total = 0;

   request_type pending_items [$];
   answer_type  expected_answers [$];
   int          errors = 0;
   int          answers_seen = 0;
   int          status_seen [6];
   bit          quiet = 1'b0;
   int          send_gap = 0;
   int          recv_gap = 0;
   logic [ohash_pkg::KEY_W-1:0]  key_pool [16];
   logic [ohash_pkg::CODE_W-1:0] code_pool [3];

   initial begin
      foreach (slot_state[i]) slot_state[i] = ohash_pkg::MARK_FREE;
      foreach (status_seen[i]) status_seen[i] = 0;
   end

   // slot visited on probe number i
   function automatic int unsigned probe_pos(logic [ohash_pkg::KEY_W-1:0] k,
                                             longint unsigned i,
                                             longint unsigned m, longint unsigned p);
      longint unsigned base;
      base = k % m;
      if (cfg_mode == ohash_pkg::MODE_QUAD) return (base + (i * i) % m) % m;
      if (cfg_mode == ohash_pkg::MODE_DH_SUB) return (base + (i * (p - k % p)) % m) % m;
      return (base + (i * (longint'(ohash_pkg::STEP_OFFSET) + k % p)) % m) % m;
   endfunction

   // walk the probe path of one request and update the table model
   function automatic void table_lookup(request_type r);
      answer_type a;
      longint unsigned m, p, tries;
      int unsigned pos;
      bit done, same;
      m = (cfg_size == 0) ? 1 : ((cfg_size > DEPTH) ? DEPTH : cfg_size);
      p = (cfg_prime == 0) ? 1 : cfg_prime;
      a.status = ohash_pkg::STATUS_FULL;
      a.slot = '0;
      a.pay = '0;
      tries = 0;
      done = 1'b0;
      while (!done && tries < m) begin
         pos = probe_pos(r.key, tries, m, p);
         same = slot_state[pos] == ohash_pkg::MARK_USED && slot_keys[pos] == r.key &&
                slot_codes[pos] == r.code;
         if (r.func == ohash_pkg::FUNC_INSERT) begin
            if (same) begin
               a.status = ohash_pkg::STATUS_DUPLICATE; a.slot = pos; done = 1'b1;
            end else if (slot_state[pos] != ohash_pkg::MARK_USED) begin
               slot_state[pos] = ohash_pkg::MARK_USED;
               slot_keys[pos] = r.key;
               slot_codes[pos] = r.code;
               slot_recs[pos] = r.pay;
               used_slots++;
               a.status = ohash_pkg::STATUS_INSERTED; a.slot = pos; done = 1'b1;
            end else begin
               tries++;
               if (tries > worst_probe) worst_probe = tries;
               if (tries == longint'(ohash_pkg::TEN_PROBES) && ten_hits < 16'hFFFF)
                  ten_hits++;
               if (coll_total < 32'hFFFF_FFFF) coll_total++;
            end
         end else if (slot_state[pos] == ohash_pkg::MARK_FREE) begin
            a.status = ohash_pkg::STATUS_NOT_FOUND; done = 1'b1;
         end else if (same) begin
            a.slot = pos; done = 1'b1;
            if (r.func == ohash_pkg::FUNC_SEARCH) begin
               a.status = ohash_pkg::STATUS_FOUND;
               a.pay = slot_recs[pos];
            end else begin
               a.status = ohash_pkg::STATUS_DELETED;
               slot_state[pos] = ohash_pkg::MARK_GONE;
               if (used_slots > 0) used_slots--;
            end
         end else begin
            tries++;
         end
      end
      a.probes = tries;
      a.elems = used_slots;
      a.max_coll = worst_probe;
      a.ten = ten_hits;
      a.sum = coll_total;
      expected_answers.push_back(a);
   endfunction

   // request driver
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready
             && ohash_pkg::func_type'(req_func) != ohash_pkg::FUNC_NOP) begin
            r.func = ohash_pkg::func_type'(req_func);
            r.key = req_entry_key;
            r.code = req_entry_code;
            r.pay = req_entry_payload;
            table_lookup(r);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               r = pending_items.pop_front();
               req_func <= r.func;
               req_entry_key <= r.key;
               req_entry_code <= r.code;
               req_entry_payload <= r.pay;
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, longint unsigned exp_v,
                                       longint unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endfunction

   // result monitor with random back-pressure
   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (rsp_status < 6) status_seen[rsp_status]++;
            if (expected_answers.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, actual status %0d",
                        $time, rsp_status);
            end else begin
               a = expected_answers.pop_front();
               check_field("status", a.status, rsp_status);
               check_field("slot_index", a.slot, rsp_slot_index);
               check_field("payload_out", a.pay, rsp_payload_out);
               check_field("probe_count", a.probes, rsp_probe_count);
               check_field("element_count", a.elems, rsp_element_count);
               check_field("max_collisions", a.max_coll, rsp_max_collisions);
               check_field("reached_ten_count", a.ten, rsp_reached_ten_count);
               check_field("total_collisions", a.sum, rsp_total_collisions);
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 5);
         end
      end
   end

   task automatic write_reg(logic [ohash_pkg::CSR_IDX_W-1:0] idx,
                            logic [ohash_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      if (idx == ohash_pkg::CSR_TABLE_SIZE) cfg_size = val;
      else if (idx == ohash_pkg::CSR_SECOND_PRIME) cfg_prime = val[ohash_pkg::PRIME_W-1:0];
      else if (idx == ohash_pkg::CSR_PROBE_MODE) cfg_mode = val[ohash_pkg::MODE_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_table(int size, int prime, int mode);
      write_reg(ohash_pkg::CSR_TABLE_SIZE, ohash_pkg::CSR_DATA_W'(size));
      write_reg(ohash_pkg::CSR_SECOND_PRIME, ohash_pkg::CSR_DATA_W'(prime));
      write_reg(ohash_pkg::CSR_PROBE_MODE, ohash_pkg::CSR_DATA_W'(mode));
   endtask

   task automatic add_item(ohash_pkg::func_type f, logic [ohash_pkg::KEY_W-1:0] k,
                           logic [ohash_pkg::CODE_W-1:0] c,
                           logic [ohash_pkg::PAY_W-1:0] p);
      request_type r;
      r.func = f; r.key = k; r.code = c; r.pay = p;
      pending_items.push_back(r);
   endtask

   // wait for all items to drain, then let a trailing no-op settle
   task automatic drain;
      while (pending_items.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // mostly entries from a small pool so inserts, hits and deletes interact
   task automatic random_phase(int count);
      int roll;
      logic [ohash_pkg::KEY_W-1:0] k;
      logic [ohash_pkg::CODE_W-1:0] c;
      ohash_pkg::func_type f;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      foreach (code_pool[i]) code_pool[i] = ohash_pkg::CODE_W'($urandom);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         f = roll < 45 ? ohash_pkg::FUNC_INSERT : roll < 75 ? ohash_pkg::FUNC_SEARCH :
             roll < 96 ? ohash_pkg::FUNC_DELETE : ohash_pkg::FUNC_NOP;
         k = $urandom_range(0, 4) == 0 ? {$urandom, $urandom}
                                       : key_pool[$urandom_range(0, 15)];
         c = $urandom_range(0, 6) == 0 ? ohash_pkg::CODE_W'($urandom)
                                       : code_pool[$urandom_range(0, 2)];
         add_item(f, k, c, $urandom);
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset setup, field extremes and every request kind
      add_item(ohash_pkg::FUNC_INSERT, '1, '1, '1);
      add_item(ohash_pkg::FUNC_INSERT, '0, '0, '0);
      add_item(ohash_pkg::FUNC_SEARCH, '1, '1, '0);
      add_item(ohash_pkg::FUNC_SEARCH, '0, '0, '1);
      add_item(ohash_pkg::FUNC_INSERT, '1, '1, 32'h1234_5678);
      add_item(ohash_pkg::FUNC_INSERT, '1, 24'h414243, 32'hA5A5_A5A5);
      add_item(ohash_pkg::FUNC_SEARCH, 64'd5, '0, '0);
      add_item(ohash_pkg::FUNC_DELETE, '1, '1, '0);
      add_item(ohash_pkg::FUNC_SEARCH, '1, '1, '0);
      add_item(ohash_pkg::FUNC_SEARCH, '1, 24'h414243, '0);
      add_item(ohash_pkg::FUNC_DELETE, 64'd77, '0, '0);
      add_item(ohash_pkg::FUNC_NOP, 64'd9, '0, '0);
      add_item(ohash_pkg::FUNC_INSERT, '1, '1, 32'h0BAD_F00D);
      drain();

      // tiny table: fill it, a full-table insert and search, then delete and re-insert
      set_table(3, 2, ohash_pkg::MODE_QUAD);
      for (int i = 0; i < 4; i++)
         add_item(ohash_pkg::FUNC_INSERT, 64'd100 + i, 24'h1, i);
      add_item(ohash_pkg::FUNC_SEARCH, 64'd500, 24'h1, '0);
      add_item(ohash_pkg::FUNC_DELETE, 64'd101, 24'h1, '0);
      add_item(ohash_pkg::FUNC_INSERT, 64'd200, 24'h2, 32'h77);
      drain();

      // zero size and zero prime, mode three
      set_table(0, 0, 3);
      add_item(ohash_pkg::FUNC_INSERT, 64'd42, 24'h3, 32'h1);
      add_item(ohash_pkg::FUNC_INSERT, 64'd43, 24'h3, 32'h2);
      add_item(ohash_pkg::FUNC_SEARCH, 64'd42, 24'h3, '0);
      drain();

      // size above the depth, largest second-prime register value
      set_table(2047, 1023, ohash_pkg::MODE_DH_SUB);
      add_item(ohash_pkg::FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 24'h5, 32'h9);
      add_item(ohash_pkg::FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFF0, 24'h5, '0);
      drain();

      // random phases over a spread of settings
      set_table(13, 11, ohash_pkg::MODE_QUAD);     random_phase(150);
      set_table(31, 29, ohash_pkg::MODE_DH_SUB);   random_phase(150);
      set_table(7, 5, 2);                          random_phase(120);
      set_table(61, 59, 2);                        random_phase(150);
      set_table(1024, 1023, ohash_pkg::MODE_QUAD); random_phase(150);
      set_table(97, 89, 3);                        random_phase(150);
      set_table(11, 2, ohash_pkg::MODE_DH_SUB);    random_phase(120);
      quiet = 1'b1;
      set_table(1021, 1019, 2);                    random_phase(150);

      $display("covered %0d results: inserted %0d, duplicate %0d, found %0d,",
               answers_seen, status_seen[0], status_seen[1], status_seen[2]);
      $display("  not found %0d, deleted %0d, table full %0d, errors %0d",
               status_seen[3], status_seen[4], status_seen[5], errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #200ms;
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
